@@ design/imucf_pkg.sv @@
// ----------------------------------------------------------------------------
// imucf_pkg
// Shared widths, register indexes, reset values and the CORDIC arctangent
// table for the IMU complementary filter.
// ----------------------------------------------------------------------------
package imucf_pkg;

  // Field widths
  localparam int IMU_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int WEIGHT_W   = 17;
  localparam int MAG_W      = 17;
  localparam int OUT_W      = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_HIGH = 2'd3;

  localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST      = 24'd327856;
  localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST   = 17'd64225;
  localparam logic [MAG_W-1:0]    MAGNITUDE_LOW_RST  = 17'd8192;
  localparam logic [MAG_W-1:0]    MAGNITUDE_HIGH_RST = 17'd32768;

  // Q16 fixed point
  localparam int FRAC_BITS = 16;
  localparam int HALF_Q16  = 32768;
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  // CORDIC datapath: x/y hold 16-bit counts scaled by 2^16 plus gain growth,
  // z holds Q16 degrees including the +/-180 degree start.
  localparam int CORDIC_W = 36;
  localparam int ZW       = 27;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 27'sd11796480;

  // Parameter defaults
  localparam int CORDIC_ITER_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 32;

  // atan(2^-i) in Q16 degrees.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117266);
      5'd6:    v = ZW'(58665);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      5'd18:   v = ZW'(14);
      5'd19:   v = ZW'(7);
      5'd20:   v = ZW'(4);
      5'd21:   v = ZW'(2);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/imucf_if.sv @@
// ----------------------------------------------------------------------------
// imucf_if
// Valid/ready channels carrying one IMU sample in and one angle result out.
// ----------------------------------------------------------------------------
interface imucf_in_if import imucf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IMU_W-1:0] gyro_x;
  logic signed [IMU_W-1:0] gyro_y;
  logic signed [IMU_W-1:0] accel_x;
  logic signed [IMU_W-1:0] accel_y;
  logic signed [IMU_W-1:0] accel_z;

  modport source (output valid, gyro_x, gyro_y, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, gyro_x, gyro_y, accel_x, accel_y, accel_z, output ready);
endinterface

interface imucf_out_if import imucf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pitch_out;
  logic signed [OUT_W-1:0] roll_out;
  logic                    accel_used;

  modport source (output valid, pitch_out, roll_out, accel_used, input ready);
  modport sink   (input valid, pitch_out, roll_out, accel_used, output ready);
endinterface

@@ design/imu_complementary_filter_core.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_filter_core
// Pitch/roll complementary filter with a shared multiplier and CORDIC unit.
//
// One beat on in_ch carries gyro x/y and accelerometer x/y/z counts; one beat
// on out_ch returns the updated pitch and roll (signed Q16 degrees) and a flag
// telling whether the accelerometer blend was applied. The cfg_ port writes
// the gain, blend weight and magnitude limits; write it only while idle.
// An item is worked on alone: in_ch.ready is high only in the idle state.
// Gyro integration runs through the shared multiplier and the saturating adder
// in S_GX, S_GY and S_RGY. When blending, each axis then runs one CORDIC
// vectoring pass: set-up, CORDIC_ITERATIONS iteration steps, multiply and
// add; an unblended item goes straight to the final state. A pass whose
// two accelerometer components are both zero skips its CORDIC iterations.
// The next beat can be taken in the cycle after the result is loaded.
// The result sits in an output register; a new input can be taken while it
// waits, and the sequencer holds in its final state only if a second result
// is ready before the first has been taken.
// Reset clears both angles to zero and loads the default register values.
// ----------------------------------------------------------------------------
module imu_complementary_filter_core import imucf_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF,
  parameter int ANGLE_WIDTH       = ANGLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  imucf_in_if.sink              in_ch,
  imucf_out_if.source           out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = ANGLE_WIDTH;
  localparam int MA   = ((AW > ZW) ? AW : ZW) + 1;   // multiplier a operand
  localparam int MB   = GAIN_W + 1;                  // multiplier b operand
  localparam int PW   = MA + MB;                     // product
  localparam int SW   = PW + 1;                      // angle update sum
  localparam int EW   = (AW > OUT_W) ? AW : OUT_W;
  localparam int ITW  = $clog2(CORDIC_ITERATIONS);
  localparam logic [ITW-1:0] ITER_LAST = ITW'(CORDIC_ITERATIONS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GX    = 4'd1;
  localparam logic [3:0] S_GY    = 4'd2;
  localparam logic [3:0] S_RGY   = 4'd3;
  localparam logic [3:0] S_CINIT = 4'd4;
  localparam logic [3:0] S_CITER = 4'd5;
  localparam logic [3:0] S_BMUL  = 4'd6;
  localparam logic [3:0] S_BADD  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  function automatic logic [IMU_W:0] abs_ext(input logic signed [IMU_W-1:0] v);
    logic signed [IMU_W:0] e;
    e = (IMU_W+1)'(v);
    return e[IMU_W] ? (IMU_W+1)'(-e) : (IMU_W+1)'(e);
  endfunction

  // Control and configuration state
  logic [3:0]           state_r;
  logic [ITW-1:0]       iter_r;
  logic                 axis_r;        // 0: pitch pass, 1: roll pass
  logic                 out_valid_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [MAG_W-1:0]     mag_low_r;
  logic [MAG_W-1:0]     mag_high_r;
  logic signed [AW-1:0] pitch_r;
  logic signed [AW-1:0] roll_r;

  // Datapath
  logic signed [IMU_W-1:0]    gx_r, gy_r, ax_r, ay_r, az_r;
  logic                       used_r;
  logic signed [PW-1:0]       prod_r;
  logic signed [CORDIC_W-1:0] x_r, y_r;
  logic signed [ZW-1:0]       z_r;
  logic signed [OUT_W-1:0]    out_pitch_r, out_roll_r;
  logic                       out_used_r;

  logic                       in_fire, out_free;
  logic [IMU_W+1:0]           mag;
  logic                       mag_ok;
  logic [WEIGHT_W-1:0]        blend_d;
  logic                       sel_roll;
  logic signed [AW-1:0]       sel_angle;
  logic signed [MA-1:0]       mul_a;
  logic signed [MB-1:0]       mul_b;
  logic signed [PW-1:0]       rnd;
  logic signed [SW-1:0]       sum;
  logic [SW-AW:0]             sum_hi;
  logic                       sum_ovf;
  logic signed [AW-1:0]       sat_val;
  logic signed [IMU_W-1:0]    yin;
  logic                       cordic_zero;
  logic signed [CORDIC_W-1:0] x0, y0, xs, ys;
  logic signed [ZW-1:0]       atan_v;
  logic signed [EW-1:0]       pitch_ext, roll_ext;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pitch_out  = out_pitch_r;
  assign out_ch.roll_out   = out_roll_r;
  assign out_ch.accel_used = out_used_r;

  assign mag    = (IMU_W+2)'(abs_ext(in_ch.accel_x)) + (IMU_W+2)'(abs_ext(in_ch.accel_y))
                + (IMU_W+2)'(abs_ext(in_ch.accel_z));
  assign mag_ok = (mag > (IMU_W+2)'(mag_low_r)) && (mag < (IMU_W+2)'(mag_high_r));

  // Weight above one is treated as one.
  assign blend_d = (weight_r > ONE_Q16) ? '0 : ONE_Q16 - weight_r;

  assign sel_roll  = (state_r == S_RGY) ||
                     (((state_r == S_BMUL) || (state_r == S_BADD)) && axis_r);
  assign sel_angle = sel_roll ? roll_r : pitch_r;

  // Shared multiplier operands: gyro times gain, then (acc - angle) times
  // (1 - weight), which equals the weighted blend less 2^16 times the angle.
  always_comb begin
    mul_a = MA'(gx_r);
    mul_b = signed'({1'b0, gain_r});
    priority if (state_r == S_GY) begin
      mul_a = MA'(gy_r);
    end else if (state_r == S_BMUL) begin
      mul_a = MA'(z_r) - MA'(sel_angle);
      mul_b = signed'(MB'(blend_d));
    end
  end

  // Shared saturating adder: angle +/- round(prod / 2^16).
  assign rnd     = (prod_r + PW'(HALF_Q16)) >>> FRAC_BITS;
  assign sum     = (state_r == S_RGY) ? SW'(sel_angle) - SW'(rnd) : SW'(sel_angle) + SW'(rnd);
  assign sum_hi  = sum[SW-1:AW-1];
  assign sum_ovf = !((&sum_hi) || !(|sum_hi));
  assign sat_val = !sum_ovf ? sum[AW-1:0] :
                   (sum[SW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}});

  // CORDIC set-up and step
  assign yin         = axis_r ? ax_r : ay_r;
  assign cordic_zero = (az_r == '0) && (yin == '0);
  assign x0          = CORDIC_W'(az_r) <<< FRAC_BITS;
  assign y0          = CORDIC_W'(yin) <<< FRAC_BITS;
  assign xs          = x_r >>> iter_r;
  assign ys          = y_r >>> iter_r;
  assign atan_v      = atan_q16(5'(iter_r));

  assign pitch_ext = EW'(pitch_r);
  assign roll_ext  = EW'(roll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= GYRO_GAIN_RST;
      weight_r    <= BLEND_WEIGHT_RST;
      mag_low_r   <= MAGNITUDE_LOW_RST;
      mag_high_r  <= MAGNITUDE_HIGH_RST;
      pitch_r     <= '0;
      roll_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_GYRO_GAIN:      gain_r     <= cfg_data[GAIN_W-1:0];
          CFG_BLEND_WEIGHT:   weight_r   <= cfg_data[WEIGHT_W-1:0];
          CFG_MAGNITUDE_LOW:  mag_low_r  <= cfg_data[MAG_W-1:0];
          CFG_MAGNITUDE_HIGH: mag_high_r <= cfg_data[MAG_W-1:0];
        endcase
      end

      // A new result replaces the one being taken in the same cycle.
      priority if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_GX;
          end
        end
        S_GX: begin
          state_r <= S_GY;
        end
        S_GY: begin
          pitch_r <= sat_val;
          state_r <= S_RGY;
        end
        S_RGY: begin
          roll_r  <= sat_val;
          axis_r  <= 1'b0;
          state_r <= used_r ? S_CINIT : S_DONE;
        end
        S_CINIT: begin
          iter_r  <= '0;
          state_r <= cordic_zero ? S_BMUL : S_CITER;
        end
        S_CITER: begin
          iter_r <= iter_r + 1'b1;
          if (iter_r == ITER_LAST) begin
            state_r <= S_BMUL;
          end
        end
        S_BMUL: begin
          state_r <= S_BADD;
        end
        S_BADD: begin
          if (axis_r) begin
            roll_r  <= sat_val;
            state_r <= S_DONE;
          end else begin
            pitch_r <= sat_val;
            axis_r  <= 1'b1;
            state_r <= S_CINIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);

    if (in_fire) begin
      gx_r   <= in_ch.gyro_x;
      gy_r   <= in_ch.gyro_y;
      ax_r   <= in_ch.accel_x;
      ay_r   <= in_ch.accel_y;
      az_r   <= in_ch.accel_z;
      used_r <= mag_ok;
    end

    if (state_r == S_CINIT) begin
      if (cordic_zero) begin
        z_r <= '0;
      end else if (az_r[IMU_W-1]) begin
        // Left half-plane: rotate by 180 degrees before vectoring.
        x_r <= -x0;
        y_r <= -y0;
        z_r <= yin[IMU_W-1] ? -DEG180_Q16 : DEG180_Q16;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (state_r == S_CITER) begin
      if (!y_r[CORDIC_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end
    end

    if ((state_r == S_DONE) && out_free) begin
      out_pitch_r <= pitch_ext[OUT_W-1:0];
      out_roll_r  <= roll_ext[OUT_W-1:0];
      out_used_r  <= used_r;
    end
  end

  // An accepted beat always starts the gyro multiply.
  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_GX)
    else $error("accepted input did not start the sequencer");

  // Without a blend the CORDIC passes are skipped.
  a_skip_cordic : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RGY) && !used_r |=> state_r == S_DONE)
    else $error("unblended item entered the CORDIC passes");

  // A new result only appears out of the final state.
  a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(state_r == S_DONE))
    else $error("result raised outside the final state");

endmodule

@@ tb/sv/imu_complementary_filter_core_tb.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_filter_core_tb
// Self-checking bench for the pitch/roll complementary filter core. A clocked
// driver feeds IMU readings from a queue and a clocked monitor compares every
// output beat with the angles worked out by a bit-accurate predictor. Directed
// corner cases come first, then randomised readings under several register
// settings, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module imu_complementary_filter_core_tb import imucf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CORDIC_STEPS = 16;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam longint ANGLE_MAX    = 64'sd2147483647;
  localparam longint ANGLE_MIN    = -64'sd2147483648;
  localparam longint HALF_TURN    = 64'sd11796480;

  typedef struct {
    logic signed [IMU_W-1:0] gx;
    logic signed [IMU_W-1:0] gy;
    logic signed [IMU_W-1:0] ax;
    logic signed [IMU_W-1:0] ay;
    logic signed [IMU_W-1:0] az;
  } imu_reading_t;

  typedef struct {
    logic [OUT_W-1:0] pitch;
    logic [OUT_W-1:0] roll;
    logic             used;
  } angles_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  imucf_in_if  in_ch ();
  imucf_out_if out_ch ();

  imu_complementary_filter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // atan(2^-i) in Q16 degrees
  longint atan_step_q16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117266, 58665, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  // Predictor copy of the filter state and registers
  longint            pitch_q16;
  longint            roll_q16;
  logic [GAIN_W-1:0]   gain_reg;
  logic [WEIGHT_W-1:0] weight_reg;
  logic [MAG_W-1:0]    mag_low_reg;
  logic [MAG_W-1:0]    mag_high_reg;

  imu_reading_t pending_readings[$];
  angles_t      angle_q[$];

  int  pushed   = 0;
  int  sent     = 0;
  int  accepted = 0;
  int  errors   = 0;
  int  cycles   = 0;
  bit  in_beat  = 1'b0;
  bit  hold_off = 1'b0;

  function automatic longint clamp_angle(longint v);
    if (v > ANGLE_MAX) return ANGLE_MAX;
    if (v < ANGLE_MIN) return ANGLE_MIN;
    return v;
  endfunction

  function automatic longint abs_count(logic signed [IMU_W-1:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Vectoring CORDIC, result in Q16 degrees.
  function automatic longint cordic_angle(longint num, longint den);
    longint x;
    longint y;
    longint z;
    longint xs;
    if (num == 0 && den == 0) return 0;
    x = den * 65536;
    y = num * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - xs;
        z = z + atan_step_q16[i];
      end else begin
        x = x - (y >>> i);
        y = y + xs;
        z = z - atan_step_q16[i];
      end
    end
    return z;
  endfunction

  function automatic longint blend_q16(longint ang, longint acc, longint w);
    return clamp_angle((w * ang + (65536 - w) * acc + 32768) >>> 16);
  endfunction

  function automatic angles_t filter_step(imu_reading_t r);
    longint  gain;
    longint  mag;
    longint  w;
    angles_t res;
    gain = longint'(gain_reg);
    pitch_q16 = clamp_angle(pitch_q16 + ((longint'(r.gx) * gain + 32768) >>> 16));
    roll_q16  = clamp_angle(roll_q16 - ((longint'(r.gy) * gain + 32768) >>> 16));
    mag = abs_count(r.ax) + abs_count(r.ay) + abs_count(r.az);
    res.used = (mag > longint'(mag_low_reg)) && (mag < longint'(mag_high_reg));
    if (res.used) begin
      w = (weight_reg > ONE_Q16) ? 64'sd65536 : longint'(weight_reg);
      pitch_q16 = blend_q16(pitch_q16, cordic_angle(r.ay, r.az), w);
      roll_q16  = blend_q16(roll_q16, cordic_angle(r.ax, r.az), w);
    end
    res.pitch = pitch_q16[OUT_W-1:0];
    res.roll  = roll_q16[OUT_W-1:0];
    return res;
  endfunction

  // 0: sender idles lightly, receiver heavily; 1: the reverse; 2: no idling.
  function automatic int idle_mode();
    if (sent < 470) return 0;
    if (sent < 940) return 1;
    return 2;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Predictor and checker: everything is sampled at the rising edge.
  always @(posedge clk) begin : monitor
    imu_reading_t r;
    angles_t      want;
    if (!rst_n) begin
      in_beat      <= 1'b0;
      pitch_q16     = 0;
      roll_q16      = 0;
      gain_reg      = GYRO_GAIN_RST;
      weight_reg    = BLEND_WEIGHT_RST;
      mag_low_reg   = MAGNITUDE_LOW_RST;
      mag_high_reg  = MAGNITUDE_HIGH_RST;
    end else begin
      in_beat <= in_ch.valid && in_ch.ready;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GYRO_GAIN:      gain_reg     = cfg_data[GAIN_W-1:0];
          CFG_BLEND_WEIGHT:   weight_reg   = cfg_data[WEIGHT_W-1:0];
          CFG_MAGNITUDE_LOW:  mag_low_reg  = cfg_data[MAG_W-1:0];
          CFG_MAGNITUDE_HIGH: mag_high_reg = cfg_data[MAG_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        r.gx = in_ch.gyro_x;
        r.gy = in_ch.gyro_y;
        r.ax = in_ch.accel_x;
        r.ay = in_ch.accel_y;
        r.az = in_ch.accel_z;
        angle_q.push_back(filter_step(r));
        accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (angle_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, pitch %0d roll %0d used %0b", $time,
                   out_ch.pitch_out, out_ch.roll_out, out_ch.accel_used);
        end else begin
          want = angle_q.pop_front();
          if (out_ch.pitch_out !== want.pitch) begin
            errors++;
            $display("%0t: pitch_out expected %0d, got %0d", $time,
                     $signed(want.pitch), out_ch.pitch_out);
          end
          if (out_ch.roll_out !== want.roll) begin
            errors++;
            $display("%0t: roll_out expected %0d, got %0d", $time,
                     $signed(want.roll), out_ch.roll_out);
          end
          if (out_ch.accel_used !== want.used) begin
            errors++;
            $display("%0t: accel_used expected %0b, got %0b", $time,
                     want.used, out_ch.accel_used);
          end
        end
      end
    end
  end

  // Input driver: a beat is held until taken, then the next one is offered.
  always @(negedge clk) begin : driver
    imu_reading_t r;
    int           gap_pct;
    gap_pct = (idle_mode() == 0) ? 13 : (idle_mode() == 1) ? 61 : 0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat) begin
      if (pending_readings.size() != 0 && $urandom_range(99) >= gap_pct) begin
        r = pending_readings.pop_front();
        sent++;
        in_ch.valid   <= 1'b1;
        in_ch.gyro_x  <= r.gx;
        in_ch.gyro_y  <= r.gy;
        in_ch.accel_x <= r.ax;
        in_ch.accel_y <= r.ay;
        in_ch.accel_z <= r.az;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (!rst_n || hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (idle_mode())
        0:       out_ch.ready <= ($urandom_range(99) >= 61);
        1:       out_ch.ready <= ($urandom_range(99) >= 13);
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  // One long output stall while readings keep coming, so the core backs up.
  initial begin : long_stall
    wait (accepted == 100);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic add_reading(input logic signed [IMU_W-1:0] gx, gy, ax, ay, az);
    imu_reading_t r;
    r.gx = gx;
    r.gy = gy;
    r.ax = ax;
    r.ay = ay;
    r.az = az;
    pending_readings.push_back(r);
    pushed++;
  endtask

  function automatic logic signed [IMU_W-1:0] spread(int unsigned span);
    return IMU_W'($urandom_range(2 * span) - span);
  endfunction

  function automatic logic signed [IMU_W-1:0] random_gyro();
    case ($urandom_range(3))
      0, 1:    return IMU_W'($urandom);
      2:       return spread(2000);
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // Mostly plausible accelerometer vectors so that the blend path is busy,
  // with some raw noise and some single-axis extremes.
  task automatic add_random_reading();
    int unsigned span;
    int unsigned kind;
    kind = $urandom_range(9);
    span = ($urandom_range(2) == 0) ? 4000 : ($urandom_range(1) ? 11000 : 30000);
    if (kind < 2) begin
      add_reading(random_gyro(), random_gyro(), IMU_W'($urandom), IMU_W'($urandom),
                  IMU_W'($urandom));
    end else if (kind == 9) begin
      add_reading(random_gyro(), random_gyro(), spread(200), spread(200),
                  $urandom_range(1) ? 16'sh7FFF : 16'sh8000);
    end else begin
      add_reading(random_gyro(), random_gyro(), spread(span), spread(span), spread(span));
    end
  endtask

  // Large gyro rates of opposite sign on the two axes walk both angles into saturation.
  task automatic add_drift_reading(input bit rising);
    logic signed [IMU_W-1:0] up;
    logic signed [IMU_W-1:0] down;
    up   = IMU_W'($urandom_range(31000, 32767));
    down = IMU_W'(0 - $urandom_range(31000, 32768));
    if (rising) add_reading(up, down, IMU_W'($urandom), IMU_W'($urandom), IMU_W'($urandom));
    else add_reading(down, up, IMU_W'($urandom), IMU_W'($urandom), IMU_W'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom_range(127)) << 17;
    write_reg(CFG_GYRO_GAIN, ($urandom_range(7) == 0) ? 24'hFFFFFF
                             : CFG_DATA_W'($urandom_range(0, 24'h60000)));
    write_reg(CFG_BLEND_WEIGHT, junk | (($urandom_range(7) == 0)
                                        ? CFG_DATA_W'($urandom_range(65537, 131071))
                                        : CFG_DATA_W'($urandom_range(0, 65536))));
    write_reg(CFG_MAGNITUDE_LOW, junk | CFG_DATA_W'($urandom_range(0, 16384)));
    write_reg(CFG_MAGNITUDE_HIGH, junk | CFG_DATA_W'($urandom_range(16385, 98304)));
  endtask

  // Waits until every beat has been taken and answered, then lets the core
  // settle back to idle before registers change.
  task automatic wait_idle();
    while (accepted != pushed || angle_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_GYRO_GAIN;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: magnitude on and around both limits, both accel
    // components zero, negative z in both half-planes, field extremes.
    add_reading(0, 0, 0, 0, 0);
    add_reading(32767, -32768, -32768, -32768, -32768);
    add_reading(-32768, 32767, 32767, 32767, 32767);
    add_reading(0, 0, 8192, 0, 0);
    add_reading(0, 0, 8193, 0, 0);
    add_reading(500, -500, 0, 20000, -5000);
    add_reading(-500, 500, -3000, -20000, -5000);
    add_reading(1200, 300, 10000, -12000, 10000);
    add_reading(0, 0, 0, 32767, 0);
    add_reading(0, 0, 0, 0, -32768);
    add_reading(-7, 7, -16383, 0, 16384);
    add_reading(100, -100, 1, -1, 9000);
    wait_idle();

    // Full gain, zero weight: the accelerometer angle replaces the state.
    write_reg(CFG_GYRO_GAIN, 24'hFFFFFF);
    write_reg(CFG_BLEND_WEIGHT, 24'd0);
    write_reg(CFG_MAGNITUDE_LOW, 24'd0);
    write_reg(CFG_MAGNITUDE_HIGH, 24'd98304);
    add_reading(32767, 32767, -32768, -32768, -32767);
    add_reading(-32768, -32768, 1, 0, 0);
    add_reading(0, 0, 0, 0, 0);
    add_reading(32767, -32768, 32767, 32767, 32767);
    wait_idle();

    // Weight above one and unused register bits set.
    write_reg(CFG_GYRO_GAIN, 24'd0);
    write_reg(CFG_BLEND_WEIGHT, 24'hFFFFFF);
    write_reg(CFG_MAGNITUDE_LOW, 24'hFE0000);
    write_reg(CFG_MAGNITUDE_HIGH, 24'h01FFFF);
    add_reading(1000, 1000, 5000, 5000, 5000);
    add_reading(-1, 1, -32768, -32768, -32768);
    wait_idle();

    // Crossed limits: the blend can never apply.
    write_reg(CFG_GYRO_GAIN, 24'd1);
    write_reg(CFG_BLEND_WEIGHT, 24'h010000);
    write_reg(CFG_MAGNITUDE_LOW, 24'd98304);
    write_reg(CFG_MAGNITUDE_HIGH, 24'd0);
    add_reading(32767, -32768, 100, 100, 100);
    add_reading(-1, 1, 0, 0, 0);
    add_reading(-32768, 32767, 5000, -5000, 5000);
    wait_idle();

    random_setup();
    repeat (250) add_random_reading();
    wait_idle();

    write_reg(CFG_GYRO_GAIN, 24'hFFFFFF);
    write_reg(CFG_MAGNITUDE_LOW, 24'd98304);
    write_reg(CFG_MAGNITUDE_HIGH, 24'd0);
    repeat (300) add_drift_reading(1'b1);
    wait_idle();

    write_reg(CFG_GYRO_GAIN, CFG_DATA_W'($urandom_range(0, 24'h40000)));
    write_reg(CFG_BLEND_WEIGHT, 24'd0);
    write_reg(CFG_MAGNITUDE_LOW, 24'd0);
    write_reg(CFG_MAGNITUDE_HIGH, 24'd98304);
    repeat (150) add_random_reading();
    wait_idle();

    write_reg(CFG_GYRO_GAIN, 24'hFFFFFF);
    write_reg(CFG_MAGNITUDE_LOW, 24'd98304);
    write_reg(CFG_MAGNITUDE_HIGH, 24'd0);
    repeat (300) add_drift_reading(1'b0);
    wait_idle();

    repeat (2) begin
      random_setup();
      repeat (200) add_random_reading();
      wait_idle();
    end

    repeat (50) @(negedge clk);
    if (errors == 0 && angle_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
